### sv/chtf_pkg.sv
`default_nettype none
package chtf_pkg;

  localparam int BUCKETS = 8192;
  localparam int POOL    = 8192;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int ENT_W   = $clog2(POOL);
  localparam int CNT_W   = 14;

  localparam logic [63:0]      FNV_OFFSET    = 64'hcbf29ce484222325;
  localparam logic [CNT_W-1:0] DEFAULT_COUNT = 14'd8191;
  localparam logic [CNT_W-1:0] MAX_COUNT     = CNT_W'(BUCKETS);

  localparam logic [1:0] REQ_FIND = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_DEL  = 2'd2;
  localparam logic [1:0] REQ_BAD  = 2'd3;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_SPACE  = 3'd4,
    ST_REJECTED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]       req;
    logic [63:0]      key;
    logic [63:0]      value;
    logic [BKT_W-1:0] bucket;
    logic             reject;
  } item_t;

  typedef struct packed {
    logic             ok;
    logic [ENT_W-1:0] idx;
  } link_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_HEAD,
    B_WALK,
    B_CMP,
    B_FREE,
    B_ALLOC
  } back_state_t;

endpackage
`default_nettype wire

### sv/chtf_front.sv
`default_nettype none
module chtf_front import chtf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       req_type,
  input  wire logic [63:0]      key,
  input  wire logic [63:0]      value,
  input  wire logic [CNT_W-1:0] bucket_count,
  input  wire logic             init_busy,
  input  wire logic             q_full,
  output logic                  busy,
  output logic                  push,
  output item_t                 push_item
);

  front_state_t     state, state_next;
  logic [63:0]      h;
  logic [3:0]       cnt;
  logic [CNT_W-1:0] m;
  logic [CNT_W-1:0] r;
  item_t            item;
  logic             accept;
  logic [63:0]      h_mul;
  logic [7:0]       byte_in;
  logic [CNT_W-1:0] r_step;
  logic [CNT_W-1:0] m_sel;

  assign busy   = (state != F_IDLE) || init_busy;
  assign accept = start && !busy;

  // prime = 2^40 + 0x1b3, done as shift-add
  assign h_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  assign byte_in = item.key[cnt[2:0]*8 +: 8];

  always_comb begin
    if (bucket_count == '0) begin
      m_sel = DEFAULT_COUNT;
    end else if (bucket_count > MAX_COUNT) begin
      m_sel = MAX_COUNT;
    end else begin
      m_sel = bucket_count;
    end
  end

  // four restoring steps per cycle; r < m so one subtract each
  always_comb begin
    logic [CNT_W-1:0] t;
    t = r;
    for (int i = 0; i < 4; i++) begin
      t = {t[CNT_W-2:0], h[63-i]};
      if (t >= m) begin
        t = t - m;
      end
    end
    r_step = t;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (key == '0 || req_type == REQ_BAD || (req_type == REQ_ADD && value == '0)) begin
            state_next = F_PUSH;
          end else begin
            state_next = F_HASH;
          end
        end
      end
      F_HASH: if (cnt == 4'd7) state_next = F_MOD;
      F_MOD:  if (cnt == 4'd15) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    push      = (state == F_PUSH) && !q_full;
    push_item = item;
    push_item.bucket = r[BKT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          item.req    <= req_type;
          item.key    <= key;
          item.value  <= value;
          item.bucket <= '0;
          item.reject <= key == '0 || req_type == REQ_BAD || (req_type == REQ_ADD && value == '0);
          h           <= FNV_OFFSET;
          cnt         <= '0;
          m           <= m_sel;
          r           <= '0;
        end
      end
      F_HASH: begin
        h   <= h_mul ^ {56'd0, byte_in};
        cnt <= (cnt == 4'd7) ? 4'd0 : cnt + 4'd1;
      end
      F_MOD: begin
        h   <= h << 4;
        r   <= r_step;
        cnt <= cnt + 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/chtf_fifo.sv
`default_nettype none
module chtf_fifo import chtf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       q_valid,
  output item_t      q_item
);

  item_t      slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full    = fill == 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

### sv/chtf_back.sv
`default_nettype none
module chtf_back import chtf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             init_busy,
  output logic             done,
  output status_t          status,
  output logic [63:0]      value_out,
  output logic [CNT_W-1:0] entry_count
);

  back_state_t      state, state_next;
  logic [ENT_W-1:0] init_idx;
  item_t            item;
  link_t            cur;
  logic [ENT_W-1:0] prev_idx;
  logic             has_prev;
  link_t            head_word;
  logic [63:0]      old_value;
  logic [ENT_W-1:0] free_head;
  logic             free_ok;
  logic [CNT_W-1:0] held;

  link_t       head_mem [BUCKETS];
  link_t       link_mem [POOL];
  logic [63:0] key_mem  [POOL];
  logic [63:0] val_mem  [POOL];

  logic             head_re, head_we;
  logic [BKT_W-1:0] head_raddr, head_waddr;
  link_t            head_q, head_wdata;
  logic             link_re, link_we;
  logic [ENT_W-1:0] link_raddr, link_waddr;
  link_t            link_q, link_wdata;
  logic             ent_re, key_we, val_we;
  logic [ENT_W-1:0] ent_raddr, ent_waddr;
  logic [63:0]      key_q, val_q, val_wdata;

  logic        fin;
  status_t     fin_status;
  logic [63:0] fin_value;
  logic        held_inc, held_dec;
  logic        hit;

  assign hit         = key_q == item.key;
  assign init_busy   = state == B_INIT;
  assign entry_count = held;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (head_re) head_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) link_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[ent_waddr] <= item.key;
    if (val_we) val_mem[ent_waddr] <= val_wdata;
    if (ent_re) begin
      key_q <= key_mem[ent_raddr];
      val_q <= val_mem[ent_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_INIT:  if (init_idx == ENT_W'(POOL - 1)) state_next = B_IDLE;
      B_IDLE:  if (q_valid && !q_item.reject) state_next = B_HEAD;
      B_HEAD:  state_next = B_WALK;
      B_WALK: begin
        if (!cur.ok) begin
          state_next = (item.req == REQ_ADD && free_ok) ? B_ALLOC : B_IDLE;
        end else begin
          state_next = B_CMP;
        end
      end
      B_CMP: begin
        if (hit) begin
          state_next = (item.req == REQ_DEL) ? B_FREE : B_IDLE;
        end else begin
          state_next = B_WALK;
        end
      end
      B_FREE:  state_next = B_IDLE;
      B_ALLOC: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    head_re    = 1'b0;
    head_raddr = q_item.bucket;
    head_we    = 1'b0;
    head_waddr = item.bucket;
    head_wdata = '0;
    link_re    = 1'b0;
    link_raddr = cur.idx;
    link_we    = 1'b0;
    link_waddr = cur.idx;
    link_wdata = '0;
    ent_re     = 1'b0;
    ent_raddr  = cur.idx;
    key_we     = 1'b0;
    val_we     = 1'b0;
    ent_waddr  = cur.idx;
    val_wdata  = item.value;
    fin        = 1'b0;
    fin_status = ST_FOUND;
    fin_value  = '0;
    held_inc   = 1'b0;
    held_dec   = 1'b0;
    case (state)
      B_INIT: begin
        // empty heads, free list i -> i+1
        head_we        = 1'b1;
        head_waddr     = BKT_W'(init_idx);
        link_we        = 1'b1;
        link_waddr     = init_idx;
        link_wdata.ok  = init_idx != ENT_W'(POOL - 1);
        link_wdata.idx = init_idx + 1'b1;
      end
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.reject) begin
            fin        = 1'b1;
            fin_status = ST_REJECTED;
          end else begin
            head_re = 1'b1;
          end
        end
      end
      B_WALK: begin
        if (!cur.ok) begin
          case (item.req)
            REQ_ADD: begin
              if (!free_ok) begin
                fin        = 1'b1;
                fin_status = ST_NO_SPACE;
              end else begin
                link_re    = 1'b1;
                link_raddr = free_head;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = ST_NOT_FOUND;
            end
          endcase
        end else begin
          ent_re  = 1'b1;
          link_re = 1'b1;
        end
      end
      B_CMP: begin
        if (hit) begin
          case (item.req)
            REQ_FIND: begin
              fin       = 1'b1;
              fin_value = val_q;
            end
            REQ_ADD: begin
              val_we     = 1'b1;
              fin        = 1'b1;
              fin_status = ST_REPLACED;
              fin_value  = val_q;
            end
            default: begin
              // unlink from predecessor or from the bucket head
              if (has_prev) begin
                link_we    = 1'b1;
                link_waddr = prev_idx;
                link_wdata = link_q;
              end else begin
                head_we    = 1'b1;
                head_wdata = link_q;
              end
            end
          endcase
        end
      end
      B_FREE: begin
        link_we        = 1'b1;
        link_wdata.ok  = free_ok;
        link_wdata.idx = free_head;
        fin            = 1'b1;
        fin_value      = old_value;
        held_dec       = 1'b1;
      end
      B_ALLOC: begin
        key_we         = 1'b1;
        val_we         = 1'b1;
        ent_waddr      = free_head;
        link_we        = 1'b1;
        link_waddr     = free_head;
        link_wdata     = head_word;
        head_we        = 1'b1;
        head_wdata.ok  = 1'b1;
        head_wdata.idx = free_head;
        fin            = 1'b1;
        fin_status     = ST_INSERTED;
        fin_value      = item.value;
        held_inc       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      init_idx  <= '0;
      free_head <= '0;
      free_ok   <= 1'b1;
      held      <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == B_INIT) init_idx <= init_idx + 1'b1;
      if (state == B_FREE) begin
        free_head <= cur.idx;
        free_ok   <= 1'b1;
      end else if (state == B_ALLOC) begin
        free_head <= link_q.idx;
        free_ok   <= link_q.ok;
      end
      if (held_inc) begin
        held <= held + 1'b1;
      end else if (held_dec && held != '0) begin
        held <= held - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    status    <= fin_status;
    value_out <= fin_value;
    if (state == B_IDLE && q_pop) begin
      item     <= q_item;
      has_prev <= 1'b0;
    end
    if (state == B_HEAD) begin
      cur       <= head_q;
      head_word <= head_q;
    end
    if (state == B_CMP) begin
      if (hit) begin
        old_value <= val_q;
      end else begin
        prev_idx <= cur.idx;
        has_prev <= 1'b1;
        cur      <= link_q;
      end
    end
  end

endmodule
`default_nettype wire

### sv/chained_hash_table_fnv_unit.sv
// Channel   Signals                                   Direction  Handshake
// request   start, req_type, key, value               in         start & !busy
// result    done, status, value_out, entry_count      out        done, one cycle
// config    cfg_we, cfg_wdata (bucket_count)          in         cfg_we
//
// Front: FNV hashing of the key bytes, then modulo (4 bits per cycle), then a
// queue push; a rejected request goes straight to the push. busy drops after
// the push and stays high while the queue is full. Back: a head read, a walk
// and compare per chain entry, plus a step to insert or delete; done is
// registered from the last step. After reset a clearing pass sets up the
// bucket heads and free list, busy high throughout. Results cannot be stalled.
`default_nettype none
module chained_hash_table_fnv_unit import chtf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       req_type,
  input  wire logic [63:0]      key,
  input  wire logic [63:0]      value,
  output logic                  done,
  output logic [2:0]            status,
  output logic [63:0]           value_out,
  output logic [CNT_W-1:0]      entry_count,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] bucket_count;
  logic             init_busy;
  logic             q_full, push, q_valid, q_pop;
  item_t            push_item, q_item;
  status_t          st;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= DEFAULT_COUNT;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  chtf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req_type),
    .key          (key),
    .value        (value),
    .bucket_count (bucket_count),
    .init_busy    (init_busy),
    .q_full       (q_full),
    .busy         (busy),
    .push         (push),
    .push_item    (push_item)
  );

  chtf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  chtf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .init_busy   (init_busy),
    .done        (done),
    .status      (st),
    .value_out   (value_out),
    .entry_count (entry_count)
  );

  assign status = st;

endmodule
`default_nettype wire
